// ----- rtl/dvru_pkg.sv -----
// dvru_pkg: shared types, codes and constants of the distance-vector route update block
// no dependencies; used by the interfaces, the route table and the top level

package dvru_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned NB_DEPTH    = TABLE_DEPTH * TABLE_DEPTH;
  localparam int unsigned NB_AW       = 2 * IDX_W;

  // field widths
  localparam int unsigned ID_W   = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned COST_W = 16;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned FUNC_W = 2;

  localparam logic [1:0]        REFRESH_VALUE = 2'd3;
  localparam logic [COST_W-1:0] COST_MAX      = 16'hFFFF;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEADER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENTRY  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_LOADED   = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_IMPROVED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_KEPT     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd5;

  // sequencer states
  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } dvru_state_t;

  // one route table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop;
  } dvru_entry_t;

  // table write control
  typedef struct packed {
    logic             load;
    logic             route;
    logic [IDX_W-1:0] addr;
  } dvru_wr_t;

endpackage

// ----- rtl/dvru_req_if.sv -----
// dvru_req_if / dvru_rsp_if: valid-ready channels for requests and results
// depends on dvru_pkg for field widths

interface dvru_req_if;
  logic                             valid;
  logic                             ready;
  logic [dvru_pkg::FUNC_W-1:0]      func;
  logic [dvru_pkg::IDX_W-1:0]       entry_index;
  logic [dvru_pkg::ID_W-1:0]        dest_id;
  logic [dvru_pkg::ADDR_W-1:0]      router_addr;
  logic [dvru_pkg::COST_W-1:0]      link_cost;
  logic [dvru_pkg::ID_W-1:0]        next_hop_in;
  logic [dvru_pkg::CNT_W-1:0]       entry_count;

  modport source (output valid, func, entry_index, dest_id, router_addr, link_cost,
                  next_hop_in, entry_count, input ready);
  modport sink (input valid, func, entry_index, dest_id, router_addr, link_cost,
                next_hop_in, entry_count, output ready);
endinterface

interface dvru_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [dvru_pkg::STAT_W-1:0]      status;
  logic [dvru_pkg::COST_W-1:0]      route_cost;
  logic [dvru_pkg::ID_W-1:0]        next_hop_out;
  logic [dvru_pkg::IDX_W-1:0]       found_index;

  modport source (output valid, status, route_cost, next_hop_out, found_index, input ready);
  modport sink (input valid, status, route_cost, next_hop_out, found_index, output ready);
endinterface

// ----- rtl/distance_vector_route_update.sv -----
// distance_vector_route_update: route table update, one request at a time, not ready meanwhile
// load, entry and unused requests: a single execution step; the result is registered on commit
// header: one table read per step, searching positions below min(entry_count, 8) in order;
//   ends on the first match or the last position; next accept in the cycle after the commit
// the shared comparator and the single table read port serialise the steps; output stalls hold the commit
// sync reset (rst_n low) clears control, sender state, refresh counts; tables stay undefined

module distance_vector_route_update (
  input  logic        clk,
  input  logic        rst_n,
  dvru_req_if.sink    in_req,
  dvru_rsp_if.source  out_rsp
);

  // sequencer and request registers
  dvru_pkg::dvru_state_t               state_r, state_nxt;
  logic [dvru_pkg::FUNC_W-1:0]         func_r;
  logic [dvru_pkg::IDX_W-1:0]          idx_r;
  logic [dvru_pkg::ID_W-1:0]           rid_r;
  logic [dvru_pkg::ADDR_W-1:0]         addr_r;
  logic [dvru_pkg::COST_W-1:0]         cost_r;
  logic [dvru_pkg::ID_W-1:0]           hop_r;
  logic [dvru_pkg::CNT_W-1:0]          count_r;
  logic [dvru_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;

  // sender state
  logic [dvru_pkg::IDX_W-1:0]          sender_index_r;
  logic [dvru_pkg::COST_W-1:0]         sender_cost_r;
  logic [dvru_pkg::ID_W-1:0]           sender_id_r;
  logic                                sender_known_r;
  logic [dvru_pkg::CNT_W-1:0]          entries_expected_r;
  logic [1:0]                          refresh_r [dvru_pkg::TABLE_DEPTH];

  // neighbour cost matrix
  logic [dvru_pkg::COST_W-1:0]         nb_mem [dvru_pkg::NB_DEPTH];

  // result register
  logic                                out_valid_r;
  logic [dvru_pkg::STAT_W-1:0]         out_status_r;
  logic [dvru_pkg::COST_W-1:0]         out_cost_r;
  logic [dvru_pkg::ID_W-1:0]           out_hop_r;
  logic [dvru_pkg::IDX_W-1:0]          out_index_r;

  // datapath
  logic                                accept;
  logic                                out_free;
  logic                                commit;
  logic                                is_header;
  logic [dvru_pkg::CNT_W-1:0]          limit;
  logic                                found;
  logic                                search_last;
  logic                                step_done;
  logic [dvru_pkg::ADDR_W-1:0]         cmp_a, cmp_b;
  logic                                cmp_eq, cmp_lt;
  logic [dvru_pkg::COST_W:0]           sum_full;
  logic [dvru_pkg::COST_W-1:0]         sum_sat;
  logic                                entry_ok;
  logic [dvru_pkg::IDX_W-1:0]          rd_addr;
  dvru_pkg::dvru_entry_t               rd_data;
  dvru_pkg::dvru_wr_t                  tbl_wr;
  dvru_pkg::dvru_entry_t               tbl_wr_data;
  logic                                nb_we;
  logic                                hdr_commit;
  logic [dvru_pkg::STAT_W-1:0]         res_status;
  logic [dvru_pkg::COST_W-1:0]         res_cost;
  logic [dvru_pkg::ID_W-1:0]           res_hop;
  logic [dvru_pkg::IDX_W-1:0]          res_index;

  assign accept    = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == dvru_pkg::SEQ_IDLE);
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign is_header = (func_r == dvru_pkg::FUNC_HEADER);

  // search limit is min(entry_count, table depth)
  assign limit = (count_r > dvru_pkg::CNT_W'(dvru_pkg::TABLE_DEPTH)) ?
                 dvru_pkg::CNT_W'(dvru_pkg::TABLE_DEPTH) : count_r;

  // saturating cost sum
  assign sum_full = {1'b0, sender_cost_r} + {1'b0, cost_r};
  assign sum_sat  = sum_full[dvru_pkg::COST_W] ? dvru_pkg::COST_MAX
                                               : sum_full[dvru_pkg::COST_W-1:0];

  // shared comparator: address match on headers, cost compare on entries
  always_comb begin
    if (is_header) begin
      cmp_a = addr_r;
      cmp_b = rd_data.addr;
    end else begin
      cmp_a = {{(dvru_pkg::ADDR_W-dvru_pkg::COST_W){1'b0}}, sum_sat};
      cmp_b = {{(dvru_pkg::ADDR_W-dvru_pkg::COST_W){1'b0}}, rd_data.cost};
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_lt = (cmp_a < cmp_b);

  // search step control
  assign found       = (cnt_r < limit) && cmp_eq;
  assign search_last = ((cnt_r + dvru_pkg::CNT_W'(1)) >= limit);
  assign step_done   = !is_header || found || search_last;
  assign commit      = (state_r == dvru_pkg::SEQ_EXEC) && step_done && out_free;
  assign hdr_commit  = commit && is_header;

  // entry acceptance (positions always lie inside the table)
  assign entry_ok = sender_known_r && ({1'b0, idx_r} < entries_expected_r) &&
                    (rd_data.id == rid_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dvru_pkg::SEQ_IDLE: begin
        if (accept) state_nxt = dvru_pkg::SEQ_EXEC;
      end
      dvru_pkg::SEQ_EXEC: begin
        if (commit) state_nxt = dvru_pkg::SEQ_IDLE;
      end
      default: state_nxt = dvru_pkg::SEQ_IDLE;
    endcase
  end

  // search counter and table read address
  always_comb begin
    cnt_nxt = cnt_r;
    rd_addr = idx_r;
    unique case (state_r)
      dvru_pkg::SEQ_IDLE: begin
        cnt_nxt = '0;
        rd_addr = (in_req.func == dvru_pkg::FUNC_HEADER) ? '0 : in_req.entry_index;
      end
      dvru_pkg::SEQ_EXEC: begin
        if (is_header && !step_done) cnt_nxt = cnt_r + dvru_pkg::CNT_W'(1);
        rd_addr = is_header ? cnt_nxt[dvru_pkg::IDX_W-1:0] : idx_r;
      end
      default: begin
        cnt_nxt = cnt_r;
        rd_addr = idx_r;
      end
    endcase
  end

  // result and write-back selection
  always_comb begin
    tbl_wr        = '0;
    tbl_wr.addr   = idx_r;
    tbl_wr_data   = '{id: rid_r, addr: addr_r, cost: cost_r, hop: hop_r};
    nb_we         = 1'b0;
    res_status    = dvru_pkg::STAT_IGNORED;
    res_cost      = '0;
    res_hop       = '0;
    res_index     = idx_r;
    unique case (func_r)
      dvru_pkg::FUNC_LOAD: begin
        tbl_wr.load = commit;
        res_status  = dvru_pkg::STAT_LOADED;
        res_cost    = cost_r;
        res_hop     = hop_r;
      end
      dvru_pkg::FUNC_HEADER: begin
        if (found) begin
          res_status = dvru_pkg::STAT_FOUND;
          res_cost   = rd_data.cost;
          res_hop    = rd_data.hop;
          res_index  = cnt_r[dvru_pkg::IDX_W-1:0];
        end else begin
          res_status = dvru_pkg::STAT_UNKNOWN;
          res_index  = '0;
        end
      end
      dvru_pkg::FUNC_ENTRY: begin
        res_cost = rd_data.cost;
        res_hop  = rd_data.hop;
        if (entry_ok) begin
          nb_we = commit;
          if (cmp_lt) begin
            tbl_wr.route     = commit;
            tbl_wr_data.cost = sum_sat;
            tbl_wr_data.hop  = sender_id_r;
            res_status       = dvru_pkg::STAT_IMPROVED;
            res_cost         = sum_sat;
            res_hop          = sender_id_r;
          end else begin
            res_status = dvru_pkg::STAT_KEPT;
          end
        end
      end
      default: begin
        res_status = dvru_pkg::STAT_IGNORED;
      end
    endcase
  end

  dvru_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .wr_data (tbl_wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // neighbour cost matrix: row is sender position, column is entry position
  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[{sender_index_r, idx_r}] <= cost_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dvru_pkg::SEQ_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_req.func;
      idx_r   <= in_req.entry_index;
      rid_r   <= in_req.dest_id;
      addr_r  <= in_req.router_addr;
      cost_r  <= in_req.link_cost;
      hop_r   <= in_req.next_hop_in;
      count_r <= in_req.entry_count;
    end
  end

  // sender state and refresh counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sender_index_r     <= '0;
      sender_cost_r      <= '0;
      sender_id_r        <= '0;
      sender_known_r     <= 1'b0;
      entries_expected_r <= '0;
      for (int i = 0; i < dvru_pkg::TABLE_DEPTH; i++) refresh_r[i] <= '0;
    end else if (hdr_commit) begin
      entries_expected_r <= count_r;
      sender_known_r     <= found;
      if (found) begin
        sender_index_r <= cnt_r[dvru_pkg::IDX_W-1:0];
        sender_cost_r  <= rd_data.cost;
        sender_id_r    <= rd_data.id;
        refresh_r[cnt_r[dvru_pkg::IDX_W-1:0]] <= dvru_pkg::REFRESH_VALUE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= res_status;
      out_cost_r   <= res_cost;
      out_hop_r    <= res_hop;
      out_index_r  <= res_index;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.route_cost   = out_cost_r;
  assign out_rsp.next_hop_out = out_hop_r;
  assign out_rsp.found_index  = out_index_r;

  // checks
  a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == dvru_pkg::SEQ_EXEC))
    else $error("accepted request did not start execution");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> $past(commit))
    else $error("result appeared without a commit");

  a_search_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvru_pkg::SEQ_EXEC) && is_header |->
      (cnt_r < dvru_pkg::CNT_W'(dvru_pkg::TABLE_DEPTH)) || (limit == '0))
    else $error("header search ran past the table");

  a_improved_hop: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (res_status == dvru_pkg::STAT_IMPROVED) |=>
      out_rsp.valid && (out_rsp.next_hop_out == sender_id_r))
    else $error("improved route does not point at the sender");

endmodule

// ----- rtl/dvru_table.sv -----
// dvru_table: route table storage with one write port and one registered read port
// depends on dvru_pkg for the entry and write-control types

module dvru_table (
  input  logic                          clk,
  input  dvru_pkg::dvru_wr_t            wr,
  input  dvru_pkg::dvru_entry_t         wr_data,
  input  logic [dvru_pkg::IDX_W-1:0]    rd_addr,
  output dvru_pkg::dvru_entry_t         rd_data
);

  dvru_pkg::dvru_entry_t mem_r [dvru_pkg::TABLE_DEPTH];
  dvru_pkg::dvru_entry_t rd_data_r;

  // write: full entry on load, cost and hop on route improvement
  always_ff @(posedge clk) begin
    if (wr.load) begin
      mem_r[wr.addr] <= wr_data;
    end else if (wr.route) begin
      mem_r[wr.addr].cost <= wr_data.cost;
      mem_r[wr.addr].hop  <= wr_data.hop;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
